### sv/dsbp_pkg.sv
// shared types, constants and opcodes of the deflate symbol bit packer
package dsbp_pkg;

	// table depths and code limits
	localparam int LITLEN_SYMBOLS = 286;
	localparam int DIST_SYMBOLS   = 30;
	localparam int MAX_CODE_BITS  = 32;
	localparam int CODE_W         = 32;
	localparam int CLEN_W         = 6;

	// symbol numbers and distance range
	localparam logic [8:0]  END_SYMBOL   = 9'd256;
	localparam logic [8:0]  LEN_SYM_BASE = 9'd257;
	localparam logic [15:0] DIST_LIMIT   = 16'h8000;

	// bit merge widths: two codes plus both extra fields, then pending bits in front
	localparam int FIELD_W     = 82;
	localparam int FIELD_LEN_W = 7;
	localparam int MERGE_W     = 96;
	localparam int BUF_BYTES   = 11;
	localparam int BUF_IDX_W   = 4;

	// item kinds carried on s_tuser
	typedef enum logic [2:0] {
		OP_LOAD_LITLEN = 3'd0,
		OP_LOAD_DIST   = 3'd1,
		OP_LITERAL     = 3'd2,
		OP_MATCH       = 3'd3,
		OP_END_BLOCK   = 3'd4
	} opcode_t;

	// one code table entry
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CLEN_W-1:0] len;
	} code_entry_t;

	// symbol numbers and extra bits derived from one input item
	typedef struct packed {
		logic [8:0]  lit_sym;
		logic        lit_ok;
		logic [4:0]  dist_sym;
		logic        dist_ok;
		logic [4:0]  len_xv;
		logic [2:0]  len_xn;
		logic [12:0] dist_xv;
		logic [3:0]  dist_xn;
	} sym_info_t;

	// first pipeline stage contents beside the table read data
	typedef struct packed {
		opcode_t     op;
		logic        lit_ok;
		logic        dist_ok;
		logic [4:0]  len_xv;
		logic [2:0]  len_xn;
		logic [12:0] dist_xv;
		logic [3:0]  dist_xn;
	} s1_t;

endpackage

### sv/dsbp_symbol_map.sv
// maps a literal, match or end-of-block item to table addresses and extra bits
module dsbp_symbol_map #(
	parameter int LITLEN_SYMBOLS = dsbp_pkg::LITLEN_SYMBOLS,
	parameter int DIST_SYMBOLS   = dsbp_pkg::DIST_SYMBOLS
) (
	input  dsbp_pkg::opcode_t   op,
	input  logic [7:0]          literal_byte,
	input  logic [7:0]          length_excess,
	input  logic [15:0]         match_distance,
	output dsbp_pkg::sym_info_t info
);

	logic [2:0]  len_msb;
	logic [4:0]  len_sym;
	logic [2:0]  len_xn;
	logic [4:0]  len_xv;
	logic [15:0] dist_c;
	logic [14:0] dist_x;
	logic [3:0]  dist_msb;
	logic [4:0]  dist_sym;
	logic [3:0]  dist_xn;
	logic [12:0] dist_xv;
	logic [8:0]  lit_sym;

	// length symbol from the position of the leading one of length minus three
	always_comb begin
		len_msb = '0;
		for (int i = 0; i < 8; i++) begin
			if (length_excess[i]) begin
				len_msb = 3'(i);
			end
		end
		if (length_excess == 8'hFF) begin
			len_sym = 5'd28;
			len_xn  = '0;
			len_xv  = '0;
		end else if (length_excess < 8'd8) begin
			len_sym = length_excess[4:0];
			len_xn  = '0;
			len_xv  = '0;
		end else begin
			len_xn  = len_msb - 3'd2;
			len_sym = {len_msb - 3'd1, 2'b00} + 5'((length_excess >> len_xn) & 8'd3);
			len_xv  = 5'(length_excess & ~(8'hFF << len_xn));
		end
	end

	// distance clamped to 1..32768, symbol from leading one of distance minus one
	always_comb begin
		if (match_distance == 16'd0) begin
			dist_c = 16'd1;
		end else if (match_distance > dsbp_pkg::DIST_LIMIT) begin
			dist_c = dsbp_pkg::DIST_LIMIT;
		end else begin
			dist_c = match_distance;
		end
		dist_x   = 15'(dist_c - 16'd1);
		dist_msb = '0;
		for (int i = 0; i < 15; i++) begin
			if (dist_x[i]) begin
				dist_msb = 4'(i);
			end
		end
		if (dist_x < 15'd4) begin
			dist_sym = dist_x[4:0];
			dist_xn  = '0;
			dist_xv  = '0;
		end else begin
			dist_xn  = dist_msb - 4'd1;
			dist_sym = {dist_msb, 1'b0} + 5'(dist_x[dist_xn]);
			dist_xv  = 13'(dist_x & ~(15'h7FFF << dist_xn));
		end
	end

	// literal/length table address for each kind of item
	always_comb begin
		case (op)
			dsbp_pkg::OP_LITERAL:   lit_sym = {1'b0, literal_byte};
			dsbp_pkg::OP_MATCH:     lit_sym = dsbp_pkg::LEN_SYM_BASE + 9'(len_sym);
			dsbp_pkg::OP_END_BLOCK: lit_sym = dsbp_pkg::END_SYMBOL;
			default:                lit_sym = '0;
		endcase
	end

	assign info.lit_sym  = lit_sym;
	assign info.lit_ok   = 10'(lit_sym) < 10'(LITLEN_SYMBOLS);
	assign info.dist_sym = dist_sym;
	assign info.dist_ok  = 6'(dist_sym) < 6'(DIST_SYMBOLS);
	assign info.len_xv   = len_xv;
	assign info.len_xn   = len_xn;
	assign info.dist_xv  = dist_xv;
	assign info.dist_xn  = dist_xn;

endmodule

### sv/dsbp_code_tables.sv
// literal/length and distance code memories with registered read
module dsbp_code_tables #(
	parameter int LITLEN_SYMBOLS = dsbp_pkg::LITLEN_SYMBOLS,
	parameter int DIST_SYMBOLS   = dsbp_pkg::DIST_SYMBOLS
) (
	input  logic                          clk,
	input  logic                          en,
	input  dsbp_pkg::opcode_t             op,
	input  logic [8:0]                    table_index,
	input  logic [dsbp_pkg::CODE_W-1:0]   code_value,
	input  logic [dsbp_pkg::CLEN_W-1:0]   code_bits,
	input  logic [8:0]                    lit_sym,
	input  logic                          lit_ok,
	input  logic [4:0]                    dist_sym,
	input  logic                          dist_ok,
	output dsbp_pkg::code_entry_t         lit_entry,
	output dsbp_pkg::code_entry_t         dist_entry
);

	localparam int LIT_AW  = $clog2(LITLEN_SYMBOLS);
	localparam int DIST_AW = (DIST_SYMBOLS > 1) ? $clog2(DIST_SYMBOLS) : 1;

	dsbp_pkg::code_entry_t lit_mem [LITLEN_SYMBOLS];
	dsbp_pkg::code_entry_t dist_mem [DIST_SYMBOLS];
	dsbp_pkg::code_entry_t wr_entry;
	dsbp_pkg::code_entry_t lit_rd_q;
	dsbp_pkg::code_entry_t dist_rd_q;
	logic [dsbp_pkg::CLEN_W-1:0] wr_len;
	logic                        lit_wr;
	logic                        dist_wr;

	// saturate the length and mask the code to it
	always_comb begin
		if (code_bits > dsbp_pkg::CLEN_W'(dsbp_pkg::MAX_CODE_BITS)) begin
			wr_len = dsbp_pkg::CLEN_W'(dsbp_pkg::MAX_CODE_BITS);
		end else begin
			wr_len = code_bits;
		end
		wr_entry.len  = wr_len;
		wr_entry.code = code_value & ~({dsbp_pkg::CODE_W{1'b1}} << wr_len);
	end

	assign lit_wr  = en && (op == dsbp_pkg::OP_LOAD_LITLEN) &&
		(10'(table_index) < 10'(LITLEN_SYMBOLS));
	assign dist_wr = en && (op == dsbp_pkg::OP_LOAD_DIST) &&
		(10'(table_index) < 10'(DIST_SYMBOLS));

	// literal/length memory
	always_ff @(posedge clk) begin
		if (lit_wr) begin
			lit_mem[table_index[LIT_AW-1:0]] <= wr_entry;
		end
		if (en && lit_ok) begin
			lit_rd_q <= lit_mem[lit_sym[LIT_AW-1:0]];
		end
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (dist_wr) begin
			dist_mem[table_index[DIST_AW-1:0]] <= wr_entry;
		end
		if (en && dist_ok) begin
			dist_rd_q <= dist_mem[dist_sym[DIST_AW-1:0]];
		end
	end

	assign lit_entry  = lit_rd_q;
	assign dist_entry = dist_rd_q;

endmodule

### sv/dsbp_bit_packer.sv
// joins codes and extra bits, prepends pending bits and drains whole bytes
module dsbp_bit_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s1_valid,
	output logic                  s1_ready,
	input  dsbp_pkg::s1_t         s1,
	input  dsbp_pkg::code_entry_t lit_entry,
	input  dsbp_pkg::code_entry_t dist_entry,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	localparam int FW = dsbp_pkg::FIELD_W;
	localparam int LW = dsbp_pkg::FIELD_LEN_W;
	localparam int MW = dsbp_pkg::MERGE_W;
	localparam int NB = dsbp_pkg::BUF_BYTES;
	localparam int IW = dsbp_pkg::BUF_IDX_W;

	logic [FW-1:0] fld;
	logic [LW-1:0] fld_len;
	logic          uses_lit;

	logic          v2_q;
	logic [FW-1:0] fld_s2;
	logic [LW-1:0] fld_len_s2;
	logic          eob_s2;

	logic [6:0]    pbits_q;
	logic [2:0]    pcnt_q;
	logic [LW-1:0] total;
	logic [MW-1:0] merged;
	logic [MW-1:0] aligned;
	logic [IW-1:0] nbytes;
	logic [6:0]    pbits_nxt;
	logic [2:0]    pcnt_nxt;
	logic          s2_go;
	logic          s3_free;

	logic          v3_q;
	logic [7:0]    obuf_q [NB];
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          last_q;
	logic          at_end;

	// code fields of the item, first bit highest
	always_comb begin
		uses_lit = (s1.op == dsbp_pkg::OP_LITERAL) || (s1.op == dsbp_pkg::OP_MATCH) ||
			(s1.op == dsbp_pkg::OP_END_BLOCK);
		fld     = '0;
		fld_len = '0;
		if (uses_lit && s1.lit_ok) begin
			fld     = FW'(lit_entry.code);
			fld_len = LW'(lit_entry.len);
		end
		if (s1.op == dsbp_pkg::OP_MATCH) begin
			fld     = (fld << s1.len_xn) | FW'(s1.len_xv);
			fld_len = fld_len + LW'(s1.len_xn);
			if (s1.dist_ok) begin
				fld     = (fld << dist_entry.len) | FW'(dist_entry.code);
				fld_len = fld_len + LW'(dist_entry.len);
			end
			fld     = (fld << s1.dist_xn) | FW'(s1.dist_xv);
			fld_len = fld_len + LW'(s1.dist_xn);
		end
	end

	assign s1_ready = !v2_q || s2_go;

	// field register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (s1_ready) begin
			v2_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s1_valid) begin
			fld_s2     <= fld;
			fld_len_s2 <= fld_len;
			eob_s2     <= (s1.op == dsbp_pkg::OP_END_BLOCK);
		end
	end

	// pending bits in front, then left align into whole bytes
	always_comb begin
		total     = fld_len_s2 + LW'(pcnt_q);
		merged    = (MW'(pbits_q) << fld_len_s2) | MW'(fld_s2);
		aligned   = merged << (LW'(MW) - total);
		nbytes    = IW'(total >> 3) + IW'(eob_s2 && (total[2:0] != 3'd0));
		pbits_nxt = merged[6:0] & ~(7'h7F << total[2:0]);
		pcnt_nxt  = total[2:0];
		if (eob_s2) begin
			pbits_nxt = '0;
			pcnt_nxt  = '0;
		end
	end

	assign at_end  = (idx_q == cnt_q - IW'(1));
	assign s3_free = !v3_q || (m_tready && at_end);
	assign s2_go   = v2_q && ((nbytes == '0) || s3_free);

	// bit accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (s2_go) begin
			pbits_q <= pbits_nxt;
			pcnt_q  <= pcnt_nxt;
		end
	end

	// output byte buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q   <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b0;
		end else if (s2_go && (nbytes != '0)) begin
			v3_q   <= 1'b1;
			cnt_q  <= nbytes;
			idx_q  <= '0;
			last_q <= eob_s2;
		end else if (v3_q && m_tready) begin
			if (at_end) begin
				v3_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// output byte buffer payload
	always_ff @(posedge clk) begin
		if (s2_go && (nbytes != '0)) begin
			for (int k = 0; k < NB; k++) begin
				obuf_q[k] <= aligned[MW-1-8*k -: 8];
			end
		end
	end

	assign m_tvalid = v3_q;
	assign m_tdata  = obuf_q[idx_q];
	assign m_tlast  = last_q && at_end;

	// a buffered item always holds at least one byte
	assert property (@(posedge clk) disable iff (!arst_n) v3_q |-> (cnt_q != '0))
		else $error("output buffer loaded with no bytes");

	// the byte index never runs past the byte count
	assert property (@(posedge clk) disable iff (!arst_n) v3_q |-> (idx_q < cnt_q))
		else $error("output byte index beyond count");

	// end of block leaves the accumulator empty
	assert property (@(posedge clk) disable iff (!arst_n) (s2_go && eob_s2) |=> (pcnt_q == '0))
		else $error("pending bits left after end of block");

	// a stalled output keeps its byte position
	assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !m_tready) |=> (v3_q && $stable(idx_q)))
		else $error("output byte moved while stalled");

endmodule

### sv/deflate_symbol_bit_packer.sv
// top level of the deflate symbol bit packer
//
// Input stream s_*: one item per handshake; s_tuser carries the opcode
// (load literal/length entry, load distance entry, literal, match, end block),
// s_tdata the table index, code, code length, literal byte, length minus three
// and match distance. Output stream m_*: one packed byte per handshake, first bit in
// bit 7; m_tlast marks the zero-padded final byte of an end-of-block item.
// Pipeline: the accept writes or reads the code memories (registered read) beside
// the input stage register, the field register then takes the joined code and
// extra bits, and the output buffer then takes the item's bytes. An item is
// accepted every cycle while no item that completes bytes waits on a busy output
// buffer; the buffer sends one byte per cycle while m_tready is high (up to eleven
// for a match), and loads and partial-byte items leave it untouched. A stalled
// m_tready holds the current byte and, once the field and table stages are full,
// drops s_tready. Reset empties the pipeline and clears the bit accumulator; code
// tables must be loaded before use.
module deflate_symbol_bit_packer #(
	parameter int LITLEN_SYMBOLS = dsbp_pkg::LITLEN_SYMBOLS,
	parameter int DIST_SYMBOLS   = dsbp_pkg::DIST_SYMBOLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// table_index[8:0], code_value[40:9], code_bits[46:41], literal_byte[54:47],
	// length_excess[62:55], match_distance[78:63], zero[79]
	input  logic [79:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	dsbp_pkg::opcode_t     op;
	dsbp_pkg::sym_info_t   info;
	dsbp_pkg::code_entry_t lit_entry;
	dsbp_pkg::code_entry_t dist_entry;
	dsbp_pkg::s1_t         s1_q;
	logic                  v1_q;
	logic                  s1_ready;
	logic                  accept;

	assign op       = dsbp_pkg::opcode_t'(s_tuser);
	assign s_tready = !v1_q || s1_ready;
	assign accept   = s_tvalid && s_tready;

	// symbol numbers and extra bits
	dsbp_symbol_map #(
		.LITLEN_SYMBOLS(LITLEN_SYMBOLS),
		.DIST_SYMBOLS  (DIST_SYMBOLS)
	) u_map (
		.op            (op),
		.literal_byte  (s_tdata[54:47]),
		.length_excess (s_tdata[62:55]),
		.match_distance(s_tdata[78:63]),
		.info          (info)
	);

	// code memories
	dsbp_code_tables #(
		.LITLEN_SYMBOLS(LITLEN_SYMBOLS),
		.DIST_SYMBOLS  (DIST_SYMBOLS)
	) u_tables (
		.clk        (clk),
		.en         (accept),
		.op         (op),
		.table_index(s_tdata[8:0]),
		.code_value (s_tdata[40:9]),
		.code_bits  (s_tdata[46:41]),
		.lit_sym    (info.lit_sym),
		.lit_ok     (info.lit_ok),
		.dist_sym   (info.dist_sym),
		.dist_ok    (info.dist_ok),
		.lit_entry  (lit_entry),
		.dist_entry (dist_entry)
	);

	// input stage beside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (s_tready) begin
			v1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.op      <= op;
			s1_q.lit_ok  <= info.lit_ok;
			s1_q.dist_ok <= info.dist_ok;
			s1_q.len_xv  <= info.len_xv;
			s1_q.len_xn  <= info.len_xn;
			s1_q.dist_xv <= info.dist_xv;
			s1_q.dist_xn <= info.dist_xn;
		end
	end

	// field join, accumulator and byte output
	dsbp_bit_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (v1_q),
		.s1_ready  (s1_ready),
		.s1        (s1_q),
		.lit_entry (lit_entry),
		.dist_entry(dist_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### sim/deflate_symbol_bit_packer_test.sv
// testbench for the deflate symbol bit packer: directed table, then random items against a predictor
module deflate_symbol_bit_packer_test;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes the block ignores
	localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

	// deflate length and distance code layout
	localparam int SHORTEST_MATCH  = 3;
	localparam int LONGEST_MATCH   = 258;
	localparam int NUM_LEN_CODES   = 29;
	localparam int NUM_DIST_CODES  = 30;
	localparam int INDEX_MAX       = 511;

	// run length
	localparam int RANDOM_ITEMS    = 450;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DRAIN_CYCLES    = 20;

	typedef struct packed {
		logic [2:0]  op;
		logic [8:0]  idx;
		logic [31:0] code;
		logic [5:0]  bits;
		logic [7:0]  lit;
		logic [7:0]  lenx;
		logic [15:0] mdist;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	// one stimulus row; typed rows carry up to four expected bytes, first in [31:24]
	typedef struct packed {
		item_t       it;
		logic        typed;
		logic [2:0]  n_typed;
		logic [31:0] typed_bytes;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// table_index, code_value, code_bits, literal_byte, length_excess, match_distance, zero
	logic [79:0] s_tdata;
	// opcode
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// out_byte
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// predictor state
	logic [31:0] litlen_code   [dsbp_pkg::LITLEN_SYMBOLS];
	logic [5:0]  litlen_len    [dsbp_pkg::LITLEN_SYMBOLS];
	bit          litlen_loaded [dsbp_pkg::LITLEN_SYMBOLS];
	logic [31:0] dist_code     [dsbp_pkg::DIST_SYMBOLS];
	logic [5:0]  dist_len      [dsbp_pkg::DIST_SYMBOLS];
	bit          dist_loaded   [dsbp_pkg::DIST_SYMBOLS];
	logic [7:0]  acc_bits  = '0;
	int          acc_count = 0;

	out_byte_t   step_bytes[$];
	out_byte_t   predicted_bytes[$];
	row_t        directed_rows[$];

	int          error_count   = 0;
	int          bytes_checked = 0;
	int          items_sent    = 0;
	int          literals_sent = 0;
	int          matches_sent  = 0;
	int          blocks_closed = 0;
	int          cycles        = 0;
	bit          source_steady = 0;
	bit          sink_steady   = 0;

	deflate_symbol_bit_packer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// append code bits msb first, completed bytes go to step_bytes
	function automatic void shift_in_bits(input logic [31:0] value, input int n);
		for (int k = n - 1; k >= 0; k--) begin
			acc_bits = {acc_bits[6:0], value[k]};
			acc_count++;
			if (acc_count == 8) begin
				step_bytes.insert(step_bytes.size(), out_byte_t'{acc_bits, 1'b0});
				acc_bits  = '0;
				acc_count = 0;
			end
		end
	endfunction

	function automatic void emit_litlen(input int sym);
		if (sym < dsbp_pkg::LITLEN_SYMBOLS)
			shift_in_bits(litlen_code[sym], int'(litlen_len[sym]));
	endfunction

	// length code: bases grow by 2^extra, extra steps up every four codes after the eighth
	function automatic void length_symbol(input int len, output int sym, output int xn,
			output int xv);
		int base;
		int ext;
		base = SHORTEST_MATCH;
		sym  = 0;
		xn   = 0;
		xv   = 0;
		if (len == LONGEST_MATCH) begin
			sym = NUM_LEN_CODES - 1;
			return;
		end
		for (int s = 0; s < NUM_LEN_CODES - 1; s++) begin
			ext = (s < 8) ? 0 : (s - 4) / 4;
			if (len >= base) begin
				sym = s;
				xn  = ext;
				xv  = len - base;
			end
			base += 1 << ext;
		end
	endfunction

	// distance code: extra steps up every two codes after the fourth
	function automatic void distance_symbol(input int distance, output int sym,
			output int xn, output int xv);
		int base;
		int ext;
		base = 1;
		sym  = 0;
		xn   = 0;
		xv   = 0;
		for (int s = 0; s < NUM_DIST_CODES; s++) begin
			ext = (s < 4) ? 0 : (s - 2) / 2;
			if (distance >= base) begin
				sym = s;
				xn  = ext;
				xv  = distance - base;
			end
			base += 1 << ext;
		end
	endfunction

	function automatic int clamp_distance(input logic [15:0] d);
		if (d == 0)
			return 1;
		if (d > dsbp_pkg::DIST_LIMIT)
			return int'(dsbp_pkg::DIST_LIMIT);
		return int'(d);
	endfunction

	// predicted bytes of one accepted item into step_bytes, state updated
	function automatic void encode_item(input item_t it);
		int          n;
		int          ls, lxn, lxv;
		int          ds, dxn, dxv;
		logic [63:0] mask;
		logic [7:0]  padded;
		step_bytes.delete();
		n    = (it.bits > dsbp_pkg::MAX_CODE_BITS) ? dsbp_pkg::MAX_CODE_BITS : int'(it.bits);
		mask = (64'd1 << n) - 64'd1;
		case (it.op)
			dsbp_pkg::OP_LOAD_LITLEN: begin
				if (it.idx < dsbp_pkg::LITLEN_SYMBOLS) begin
					litlen_code[it.idx]   = it.code & mask[31:0];
					litlen_len[it.idx]    = 6'(n);
					litlen_loaded[it.idx] = 1'b1;
				end
			end
			dsbp_pkg::OP_LOAD_DIST: begin
				if (it.idx < dsbp_pkg::DIST_SYMBOLS) begin
					dist_code[it.idx]   = it.code & mask[31:0];
					dist_len[it.idx]    = 6'(n);
					dist_loaded[it.idx] = 1'b1;
				end
			end
			dsbp_pkg::OP_LITERAL: begin
				emit_litlen(int'(it.lit));
				literals_sent++;
			end
			dsbp_pkg::OP_MATCH: begin
				length_symbol(int'(it.lenx) + SHORTEST_MATCH, ls, lxn, lxv);
				distance_symbol(clamp_distance(it.mdist), ds, dxn, dxv);
				emit_litlen(int'(dsbp_pkg::LEN_SYM_BASE) + ls);
				shift_in_bits(32'(lxv), lxn);
				if (ds < dsbp_pkg::DIST_SYMBOLS)
					shift_in_bits(dist_code[ds], int'(dist_len[ds]));
				shift_in_bits(32'(dxv), dxn);
				matches_sent++;
			end
			dsbp_pkg::OP_END_BLOCK: begin
				emit_litlen(int'(dsbp_pkg::END_SYMBOL));
				if (acc_count != 0) begin
					padded = acc_bits << (8 - acc_count);
					step_bytes.insert(step_bytes.size(), out_byte_t'{padded, 1'b0});
				end
				if (step_bytes.size() > 0)
					step_bytes[step_bytes.size() - 1].last = 1'b1;
				acc_bits  = '0;
				acc_count = 0;
				blocks_closed++;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int random_code_bits();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 75)
			return $urandom_range(1, 15);
		if (r < 92)
			return $urandom_range(16, dsbp_pkg::MAX_CODE_BITS);
		return $urandom_range(dsbp_pkg::MAX_CODE_BITS + 1, 63);
	endfunction

	// all fields but the opcode (a literal) random; the caller sets what matters
	function automatic item_t noise_item();
		item_t it;
		it.op    = dsbp_pkg::OP_LITERAL;
		it.idx   = 9'($urandom_range(0, INDEX_MAX));
		it.code  = $urandom;
		it.bits  = 6'($urandom_range(0, 63));
		it.lit   = 8'($urandom_range(0, 255));
		it.lenx  = 8'($urandom_range(0, 255));
		it.mdist = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic row_t as_row(input item_t it);
		row_t r;
		r.it          = it;
		r.typed       = 1'b0;
		r.n_typed     = '0;
		r.typed_bytes = '0;
		return r;
	endfunction

	function automatic int next_gap();
		int r;
		if (source_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	function automatic void add_row(input logic [2:0] op, input logic [8:0] idx,
			input logic [31:0] code, input logic [5:0] bits, input logic [7:0] lit,
			input logic [7:0] lenx, input logic [15:0] distance, input logic typed,
			input logic [2:0] n_typed, input logic [31:0] typed_bytes);
		row_t r;
		r.it.op       = op;
		r.it.idx      = idx;
		r.it.code     = code;
		r.it.bits     = bits;
		r.it.lit      = lit;
		r.it.lenx     = lenx;
		r.it.mdist    = distance;
		r.typed       = typed;
		r.n_typed     = n_typed;
		r.typed_bytes = typed_bytes;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// drive one item, wait for the handshake, then queue what it should produce
	task automatic send_item(input row_t r, input int gap);
		logic last;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.it.op;
		s_tdata  <= {1'b0, r.it.mdist, r.it.lenx, r.it.lit, r.it.bits, r.it.code, r.it.idx};
		do @(posedge clk); while (!s_tready);
		encode_item(r.it);
		items_sent++;
		if (r.typed) begin
			for (int k = 0; k < r.n_typed; k++) begin
				last = (r.it.op == dsbp_pkg::OP_END_BLOCK) && (k == r.n_typed - 1);
				predicted_bytes.insert(predicted_bytes.size(),
					out_byte_t'{r.typed_bytes[31 - 8 * k -: 8], last});
			end
		end else begin
			foreach (step_bytes[k])
				predicted_bytes.insert(predicted_bytes.size(), step_bytes[k]);
		end
	endtask

	// load a table entry first if an item is about to read it
	task automatic load_if_missing(input bit dist_table, input int idx);
		item_t it;
		if (dist_table ? dist_loaded[idx] : litlen_loaded[idx])
			return;
		it      = noise_item();
		it.op   = dist_table ? dsbp_pkg::OP_LOAD_DIST : dsbp_pkg::OP_LOAD_LITLEN;
		it.idx  = 9'(idx);
		it.bits = 6'(random_code_bits());
		send_item(as_row(it), next_gap());
	endtask

	// cycle count and timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycles,
				predicted_bytes.size());
			$display("deflate_symbol_bit_packer_test: done, errors");
			$finish;
		end
	end

	// output side: check each accepted byte, random stalls on m_tready
	initial begin
		out_byte_t want;
		int        stall_left;
		int        r;
		stall_left = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (predicted_bytes.size() == 0) begin
					$error("unexpected item: out_byte %02h last_byte %0b", m_tdata, m_tlast);
					error_count++;
				end else begin
					want = predicted_bytes.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_byte: expected %0b, got %0b", want.last, m_tlast);
						error_count++;
					end
				end
				bytes_checked++;
			end
			if (cycles % 500 == 0)
				sink_steady = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!sink_steady && $urandom_range(0, 99) < 30) begin
					r = $urandom_range(0, 99);
					if (r < 70)
						stall_left = $urandom_range(1, 2);
					else if (r < 92)
						stall_left = $urandom_range(3, 8);
					else
						stall_left = $urandom_range(15, 30);
				end
			end
		end
	end

	// input side: reset, directed table, random items, drain
	initial begin
		item_t it;
		int    target, r;
		int    ls, ds, xn, xv;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;

		// op, index, code, bits, literal, length-3, distance, typed, count, bytes
		// end block with an empty code and nothing pending gives nothing
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd256, 32'hFFFF_FFFF, 6'd0, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_END_BLOCK, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 0, 32'h0);
		// widest code and an overlong length that saturates
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd0, 32'hFFFF_FFFF, 6'd32, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_LITERAL, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 4, 32'hFFFF_FFFF);
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd255, 32'h0000_00A5, 6'd63, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_LITERAL, 9'd0, 32'h0, 6'd0, 8'd255, 8'd0, 16'd0,
			1, 4, 32'h0000_00A5);
		// seven-bit end code padded into one last byte
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd256, 32'hFFFF_FFFF, 6'd7, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_END_BLOCK, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 1, 32'hFE00_0000);
		// loads past the end of either table are dropped
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd300, 32'h1234_5678, 6'd5, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd511, 32'h1234_5678, 6'd5, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_DIST, 9'd30, 32'h1234_5678, 6'd5, 8'd0, 8'd0, 16'd0,
			1, 0, 32'h0);
		// length and distance codes for the matches below
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd257, 32'h1, 6'd1, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd284, 32'hFFFF_FFF5, 6'd3, 8'd0, 8'd0, 16'd0,
			0, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_LITLEN, 9'd285, 32'h3, 6'd2, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_DIST, 9'd0, 32'h0, 6'd5, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_DIST, 9'd29, 32'h1F, 6'd5, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_LOAD_DIST, 9'd4, 32'h2, 6'd2, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		// shortest match with distance zero, longest match at the farthest distance,
		// distance above the limit, one distance extra bit
		add_row(dsbp_pkg::OP_MATCH, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_MATCH, 9'd0, 32'h0, 6'd0, 8'd0, 8'd255, 16'd32768, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_MATCH, 9'd0, 32'h0, 6'd0, 8'd0, 8'd254, 16'd65535, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_MATCH, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd6, 0, 0, 32'h0);
		// opcodes with no meaning
		add_row(OP_RESERVED_FIRST, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 0, 32'h0);
		add_row(OP_RESERVED_LAST, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 0, 32'h0);
		// literal on top of pending bits, then close twice
		add_row(dsbp_pkg::OP_LITERAL, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_END_BLOCK, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 0, 0, 32'h0);
		add_row(dsbp_pkg::OP_END_BLOCK, 9'd0, 32'h0, 6'd0, 8'd0, 8'd0, 16'd0, 1, 1, 32'hFE00_0000);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i], next_gap());

		// random items, table entries loaded before any symbol reads them
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if (items_sent % 40 == 0)
				source_steady = ($urandom_range(0, 3) == 0);
			it = noise_item();
			r  = $urandom_range(0, 99);
			if (r < 10) begin
				it.op   = dsbp_pkg::OP_LOAD_LITLEN;
				it.bits = 6'(random_code_bits());
				if ($urandom_range(0, 9) == 0)
					it.idx = 9'($urandom_range(dsbp_pkg::LITLEN_SYMBOLS, INDEX_MAX));
				else
					it.idx = 9'($urandom_range(0, dsbp_pkg::LITLEN_SYMBOLS - 1));
			end else if (r < 16) begin
				it.op   = dsbp_pkg::OP_LOAD_DIST;
				it.bits = 6'(random_code_bits());
				if ($urandom_range(0, 9) == 0)
					it.idx = 9'($urandom_range(dsbp_pkg::DIST_SYMBOLS, INDEX_MAX));
				else
					it.idx = 9'($urandom_range(0, dsbp_pkg::DIST_SYMBOLS - 1));
			end else if (r < 52) begin
				it.op = dsbp_pkg::OP_LITERAL;
				load_if_missing(1'b0, int'(it.lit));
			end else if (r < 88) begin
				it.op = dsbp_pkg::OP_MATCH;
				r = $urandom_range(0, 99);
				if (r < 40)
					it.mdist = 16'($urandom_range(1, dsbp_pkg::DIST_LIMIT));
				else if (r < 75)
					it.mdist = 16'($urandom_range(1, 300));
				else if (r < 85)
					it.mdist = 16'($urandom_range(dsbp_pkg::DIST_LIMIT + 1, 65535));
				else if (r < 90)
					it.mdist = '0;
				else
					it.mdist = dsbp_pkg::DIST_LIMIT;
				length_symbol(int'(it.lenx) + SHORTEST_MATCH, ls, xn, xv);
				distance_symbol(clamp_distance(it.mdist), ds, xn, xv);
				load_if_missing(1'b0, int'(dsbp_pkg::LEN_SYM_BASE) + ls);
				load_if_missing(1'b1, ds);
			end else if (r < 97) begin
				it.op = dsbp_pkg::OP_END_BLOCK;
				load_if_missing(1'b0, int'(dsbp_pkg::END_SYMBOL));
			end else begin
				it.op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
			end
			send_item(as_row(it), next_gap());
		end
		s_tvalid <= 1'b0;

		// let every expected byte arrive, then watch for strays
		while (predicted_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items: %0d literals, %0d matches, %0d block ends", items_sent,
			literals_sent, matches_sent, blocks_closed);
		$display("checked %0d packed bytes in %0d cycles", bytes_checked, cycles);
		if (error_count == 0)
			$display("deflate_symbol_bit_packer_test: done, clean");
		else
			$display("deflate_symbol_bit_packer_test: done, errors");
		$finish;
	end

endmodule

### filelist.f
sv/dsbp_pkg.sv
sv/dsbp_symbol_map.sv
sv/dsbp_code_tables.sv
sv/dsbp_bit_packer.sv
sv/deflate_symbol_bit_packer.sv
sim/deflate_symbol_bit_packer_test.sv
